// ===== rtl/core/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// Lottery slot select package
// Shared widths, codes, reset seeds and generator constants.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 64;
  localparam int unsigned TICKET_BITS_DEF = 16;

  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned TICKETS_W  = 16;
  localparam int unsigned WINNER_W   = 6;
  localparam int unsigned RNG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_Z = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_W = 1'b1;

  localparam logic [RNG_W-1:0] SEED_Z_RESET = 32'h45acbd23;
  localparam logic [RNG_W-1:0] SEED_W_RESET = 32'h7845ff2a;
  localparam logic [15:0]      MWC_Z_MUL    = 16'd36969;
  localparam logic [15:0]      MWC_W_MUL    = 16'd18000;

  typedef struct packed {
    logic load_z;
    logic load_w;
    logic step;
  } gen_ctrl_t;

endpackage

// ===== rtl/core/lss_if.sv =====
// ----------------------------------------------------------------------------
// Lottery slot select channels
// Valid/ready channels for slot and draw requests and for draw results.
// ----------------------------------------------------------------------------
interface lss_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lss_pkg::SLOT_W-1:0]    slot;
  logic                        runnable;
  logic [lss_pkg::TICKETS_W-1:0] tickets;

  modport source(output valid, kind, slot, runnable, tickets, input ready);
  modport sink(input valid, kind, slot, runnable, tickets, output ready);
endinterface

interface lss_out_if;
  logic                       valid;
  logic                       ready;
  logic [lss_pkg::WINNER_W-1:0] winner;
  logic                       found;

  modport source(output valid, winner, found, input ready);
  modport sink(input valid, winner, found, output ready);
endinterface

// ===== rtl/core/lss_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Slot table
// One-port-write, one-port-read synchronous memory of runnable flags and
// ticket counts, with a valid bit per entry so that unwritten slots read empty.
// ----------------------------------------------------------------------------
module lss_slot_mem #(
  parameter int unsigned NUM_SLOTS   = lss_pkg::NUM_SLOTS_DEF,
  parameter int unsigned TICKET_BITS = lss_pkg::TICKET_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(NUM_SLOTS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [IDX_W-1:0]       waddr_i,
  input  logic                   wactive_i,
  input  logic [TICKET_BITS-1:0] wtickets_i,
  input  logic                   re_i,
  input  logic [IDX_W-1:0]       raddr_i,
  output logic                   ractive_o,
  output logic [TICKET_BITS-1:0] rtickets_o
);

  logic [TICKET_BITS:0]   mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   valid_q;
  logic [TICKET_BITS:0]   rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wactive_i, wtickets_i};
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign ractive_o  = rvalid_q & rdata_q[TICKET_BITS];
  assign rtickets_o = rvalid_q ? rdata_q[TICKET_BITS-1:0] : '0;

endmodule

// ===== rtl/core/lss_mwc.sv =====
// ----------------------------------------------------------------------------
// Multiply-with-carry generator
// Two 32-bit halves, each advanced by a 16 by 16 bit multiply and an add.
// ----------------------------------------------------------------------------
module lss_mwc (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lss_pkg::gen_ctrl_t              ctrl_i,
  input  logic [lss_pkg::CFG_DATA_W-1:0]  seed_i,
  output logic [lss_pkg::RNG_W-1:0]       rand_o
);

  logic [lss_pkg::RNG_W-1:0] gen_z_q, gen_z_d;
  logic [lss_pkg::RNG_W-1:0] gen_w_q, gen_w_d;
  logic [lss_pkg::RNG_W-1:0] z_prod, w_prod;

  assign z_prod = 32'(lss_pkg::MWC_Z_MUL) * 32'(gen_z_q[15:0]);
  assign w_prod = 32'(lss_pkg::MWC_W_MUL) * 32'(gen_w_q[15:0]);

  always_comb begin
    gen_z_d = gen_z_q;
    gen_w_d = gen_w_q;
    if (ctrl_i.step) begin
      gen_z_d = z_prod + {16'd0, gen_z_q[31:16]};
      gen_w_d = w_prod + {16'd0, gen_w_q[31:16]};
    end
    if (ctrl_i.load_z) begin
      gen_z_d = 32'(seed_i);
    end
    if (ctrl_i.load_w) begin
      gen_w_d = 32'(seed_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_z_q <= lss_pkg::SEED_Z_RESET;
      gen_w_q <= lss_pkg::SEED_W_RESET;
    end else begin
      gen_z_q <= gen_z_d;
      gen_w_q <= gen_w_d;
    end
  end

  assign rand_o = {gen_z_q[15:0], 16'd0} + gen_w_q;

endmodule

// ===== rtl/core/lss_div.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one dividend bit per cycle, giving the remainder only.
// ----------------------------------------------------------------------------
module lss_div #(
  parameter int unsigned SUM_W = 22
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lss_pkg::RNG_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [SUM_W-1:0]          rem_o
);

  localparam int unsigned CNT_W = $clog2(lss_pkg::RNG_W + 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [lss_pkg::RNG_W-1:0] dvd_q;
  logic [SUM_W-1:0]          dvs_q;
  logic [SUM_W-1:0]          rem_q;
  logic [SUM_W:0]            trial;
  logic [SUM_W:0]            diff;
  logic [SUM_W-1:0]          rem_d;

  assign trial = {rem_q, dvd_q[lss_pkg::RNG_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = (trial >= {1'b0, dvs_q}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(lss_pkg::RNG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[lss_pkg::RNG_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/lottery_slot_select.sv =====
// ----------------------------------------------------------------------------
// Lottery slot select
// A write item is accepted only while idle. A draw makes one table scan for
// the total and, if that is nonzero, 32 remainder steps and a second scan that
// stops at the winner; the single slot table port makes the scans serial.
// Reset is asynchronous; the table reads empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
module lottery_slot_select #(
  parameter int unsigned NUM_SLOTS   = lss_pkg::NUM_SLOTS_DEF,
  parameter int unsigned TICKET_BITS = lss_pkg::TICKET_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lss_in_if.sink                          in_i,
  lss_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [lss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam int unsigned SUM_W = TICKET_BITS + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_PICK,
    ST_OUT
  } state_e;

  state_e                     state_q;
  logic [IDX_W-1:0]           cnt_q;
  logic                       issue_q;
  logic                       rd_vld_q;
  logic                       rd_last_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic [SUM_W-1:0]           acc_q;
  logic [SUM_W-1:0]           pick_q;
  logic [IDX_W-1:0]           win_q;
  logic                       found_q;
  logic                       out_valid_q;
  logic [lss_pkg::WINNER_W-1:0] out_winner_q;
  logic                       out_found_q;

  logic                       in_xfer;
  logic                       wr_en;
  logic [TICKET_BITS-1:0]     wr_tickets;
  logic                       rd_active;
  logic [TICKET_BITS-1:0]     rd_tickets;
  logic [SUM_W-1:0]           acc_d;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           div_rem;
  logic [lss_pkg::RNG_W-1:0]  rand_word;
  lss_pkg::gen_ctrl_t         gen_ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign wr_en      = in_xfer && (in_i.kind == lss_pkg::KIND_WRITE) &&
                      (32'(in_i.slot) < 32'(NUM_SLOTS));
  assign wr_tickets = TICKET_BITS'(in_i.tickets);

  assign gen_ctrl.step   = in_xfer && (in_i.kind == lss_pkg::KIND_DRAW);
  assign gen_ctrl.load_z = cfg_we_i && (cfg_idx_i == lss_pkg::CFG_SEED_Z);
  assign gen_ctrl.load_w = cfg_we_i && (cfg_idx_i == lss_pkg::CFG_SEED_W);

  assign acc_d     = acc_q + (rd_active ? SUM_W'(rd_tickets) : '0);
  assign div_start = (state_q == ST_SUM) && rd_vld_q && rd_last_q && (acc_d != '0);

  lss_slot_mem #(
    .NUM_SLOTS   (NUM_SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (wr_en),
    .waddr_i    (IDX_W'(in_i.slot)),
    .wactive_i  (in_i.runnable),
    .wtickets_i (wr_tickets),
    .re_i       (issue_q),
    .raddr_i    (cnt_q),
    .ractive_o  (rd_active),
    .rtickets_o (rd_tickets)
  );

  lss_mwc u_mwc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (cfg_data_i),
    .rand_o (rand_word)
  );

  lss_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rand_word),
    .divisor_i  (acc_d),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_idx_q    <= '0;
      acc_q       <= '0;
      pick_q      <= '0;
      win_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_winner_q <= '0;
      out_found_q <= 1'b0;
    end else begin
      rd_vld_q <= issue_q;
      if (issue_q) begin
        cnt_q     <= cnt_q + 1'b1;
        rd_idx_q  <= cnt_q;
        rd_last_q <= (cnt_q == LAST_IDX);
        if (cnt_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (gen_ctrl.step) begin
            cnt_q   <= '0;
            issue_q <= 1'b1;
            acc_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (rd_vld_q) begin
            acc_q <= acc_d;
            if (rd_last_q) begin
              if (acc_d == '0) begin
                win_q   <= '0;
                found_q <= 1'b0;
                state_q <= ST_OUT;
              end else begin
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            pick_q  <= div_rem;
            acc_q   <= '0;
            cnt_q   <= '0;
            issue_q <= 1'b1;
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (rd_vld_q) begin
            acc_q <= acc_d;
            if (rd_active && (acc_d > pick_q)) begin
              win_q   <= rd_idx_q;
              found_q <= 1'b1;
              issue_q <= 1'b0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_winner_q <= lss_pkg::WINNER_W'(win_q);
            out_found_q  <= found_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.winner = out_winner_q;
  assign out_o.found  = out_found_q;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Lottery slot select testbench
// Drives slot writes and draws over valid/ready channels with random sender
// bursts and receiver stalls. It programs the generator seeds between phases
// and checks every draw result against a built-in lottery predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS        = lss_pkg::NUM_SLOTS_DEF;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 80;
  localparam int unsigned QUIET_LIMIT  = 5000;

  typedef struct packed {
    logic                          kind;
    logic [lss_pkg::SLOT_W-1:0]    slot;
    logic                          runnable;
    logic [lss_pkg::TICKETS_W-1:0] tickets;
  } slot_req_t;

  typedef struct packed {
    logic [lss_pkg::WINNER_W-1:0] winner;
    logic                         found;
  } draw_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [lss_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lss_pkg::CFG_DATA_W-1:0] cfg_data;

  lss_in_if  req_ch();
  lss_out_if res_ch();

  lottery_slot_select dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  logic [lss_pkg::RNG_W-1:0]     mwc_z = lss_pkg::SEED_Z_RESET;
  logic [lss_pkg::RNG_W-1:0]     mwc_w = lss_pkg::SEED_W_RESET;
  logic [lss_pkg::TICKETS_W-1:0] slot_weight [SLOTS];
  logic                          slot_live   [SLOTS];

  draw_result_t draws_due[$];
  int unsigned  mismatches = 0;
  int unsigned  burst_left = 0;
  bit           gapless    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int n = 0; n < SLOTS; n++) begin
      slot_weight[n] = '0;
      slot_live[n]   = 1'b0;
    end
  end

  function automatic draw_result_t predict_draw();
    logic [lss_pkg::RNG_W-1:0] word;
    logic [31:0]               total;
    logic [31:0]               pick;
    logic [31:0]               acc;
    draw_result_t              res;
    res   = '0;
    mwc_z = lss_pkg::MWC_Z_MUL * mwc_z[15:0] + mwc_z[31:16];
    mwc_w = lss_pkg::MWC_W_MUL * mwc_w[15:0] + mwc_w[31:16];
    word  = {mwc_z[15:0], 16'h0000} + mwc_w;
    total = '0;
    for (int n = 0; n < SLOTS; n++)
      if (slot_live[n]) total += 32'(slot_weight[n]);
    if (total != 0) begin
      pick = word % total;
      acc  = '0;
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_live[n] && !res.found) begin
          acc += 32'(slot_weight[n]);
          if (acc > pick) begin
            res.winner = n[lss_pkg::WINNER_W-1:0];
            res.found  = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic slot_req_t random_item(input int unsigned span);
    slot_req_t item;
    item.kind     = ($urandom_range(0, 9) < 4) ? lss_pkg::KIND_DRAW : lss_pkg::KIND_WRITE;
    item.slot     = lss_pkg::SLOT_W'($urandom_range(0, span - 1));
    item.runnable = ($urandom_range(0, 9) < 8);
    case ($urandom_range(0, 9))
      0, 1, 2: item.tickets = lss_pkg::TICKETS_W'($urandom_range(1, 15));
      3, 4, 5: item.tickets = lss_pkg::TICKETS_W'($urandom);
      6:       item.tickets = '0;
      7, 8:    item.tickets = lss_pkg::TICKETS_W'($urandom_range(16'hff00, 16'hffff));
      default: item.tickets = 16'h0001 << $urandom_range(0, 15);
    endcase
    if (item.kind == lss_pkg::KIND_DRAW) begin
      item.slot     = lss_pkg::SLOT_W'($urandom);
      item.runnable = 1'($urandom);
      item.tickets  = lss_pkg::TICKETS_W'($urandom);
    end
    return item;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned due,
                                 input int unsigned got);
    $display("%0t: draw %s mismatch: expected %0d, got %0d", $time, field, due, got);
    mismatches++;
  endtask

  task automatic send_item(input slot_req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gapless ? 0 : $urandom_range(0, 25);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= item.kind;
    req_ch.slot     <= item.slot;
    req_ch.runnable <= item.runnable;
    req_ch.tickets  <= item.tickets;
    do @(posedge clk_i); while (!req_ch.ready);
    if (item.kind == lss_pkg::KIND_DRAW) begin
      draws_due.push_back(predict_draw());
    end else begin
      slot_live[item.slot]   = item.runnable;
      slot_weight[item.slot] = item.tickets;
    end
  endtask

  task automatic write_slot(input int unsigned slot, input bit runnable,
                            input int unsigned tickets);
    slot_req_t item;
    item = '{kind: lss_pkg::KIND_WRITE, slot: lss_pkg::SLOT_W'(slot), runnable: runnable,
             tickets: lss_pkg::TICKETS_W'(tickets)};
    send_item(item);
  endtask

  task automatic draw();
    slot_req_t item;
    item = '{kind: lss_pkg::KIND_DRAW, slot: lss_pkg::SLOT_W'($urandom),
             runnable: 1'($urandom), tickets: lss_pkg::TICKETS_W'($urandom)};
    send_item(item);
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (draws_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_seed(input logic [lss_pkg::CFG_IDX_W-1:0] idx,
                          input logic [lss_pkg::RNG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == lss_pkg::CFG_SEED_Z) mwc_z = value;
    else mwc_w = value;
    @(posedge clk_i);
  endtask

  task automatic test_empty_lottery();
    draw();
    write_slot(5, 1'b0, 100);
    draw();
    write_slot(7, 1'b1, 0);
    draw();
  endtask

  task automatic test_ticket_extremes();
    write_slot(SLOTS - 1, 1'b1, 16'hffff);
    send_item('{kind: lss_pkg::KIND_DRAW, slot: '1, runnable: 1'b1, tickets: '1});
    write_slot(0, 1'b1, 1);
    draw();
    draw();
    write_slot(0, 1'b0, 16'hffff);
    draw();
    write_slot(SLOTS - 1, 1'b1, 0);
    draw();
  endtask

  task automatic test_seed_extremes();
    write_slot(10, 1'b1, 1000);
    write_slot(40, 1'b1, 3000);
    quiesce();
    set_seed(lss_pkg::CFG_SEED_Z, '0);
    draw();
    draw();
    quiesce();
    set_seed(lss_pkg::CFG_SEED_Z, lss_pkg::SEED_Z_RESET);
    set_seed(lss_pkg::CFG_SEED_W, '0);
    draw();
    draw();
    quiesce();
    set_seed(lss_pkg::CFG_SEED_Z, 32'h0000_0001);
    set_seed(lss_pkg::CFG_SEED_W, 32'hffff_ffff);
    draw();
    draw();
  endtask

  task automatic test_random_lottery();
    for (int phase = 0; phase < 4; phase++) begin
      quiesce();
      if (phase == 1) begin
        set_seed(lss_pkg::CFG_SEED_Z, 32'hffff_ffff);
        set_seed(lss_pkg::CFG_SEED_W, 32'h0000_0001);
      end else begin
        set_seed(lss_pkg::CFG_SEED_Z, $urandom_range(1, 32'hffff_ffff));
        set_seed(lss_pkg::CFG_SEED_W, $urandom_range(1, 32'hffff_ffff));
      end
      gapless = (phase == 2);
      for (int n = 0; n < 160; n++)
        send_item(random_item((phase % 2 == 0) ? 8 : SLOTS));
    end
    gapless = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= lss_pkg::CFG_SEED_Z;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= lss_pkg::KIND_WRITE;
    req_ch.slot     <= '0;
    req_ch.runnable <= 1'b0;
    req_ch.tickets  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_lottery();
    test_ticket_extremes();
    test_seed_extremes();
    test_random_lottery();
    quiesce();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : result_stalls
    int unsigned ready_mode;
    logic [31:0] ready_pattern;
    logic [5:0]  ready_phase;
    res_ch.ready <= 1'b0;
    ready_mode    = 0;
    ready_pattern = '1;
    ready_phase   = '0;
    forever begin
      @(posedge clk_i);
      if (ready_phase == 0) begin
        ready_mode    = $urandom_range(0, 2);
        ready_pattern = $urandom;
      end
      case (ready_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= ready_pattern[ready_phase[4:0]];
        default: res_ch.ready <= (ready_phase[3:0] == ready_pattern[3:0]);
      endcase
      ready_phase++;
    end
  end

  always @(posedge clk_i) begin : check_draws
    draw_result_t due;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (draws_due.size() == 0) begin
        report_mismatch("unexpected result, winner", 0, 32'(res_ch.winner));
      end else begin
        due = draws_due.pop_front();
        if (res_ch.winner !== due.winner)
          report_mismatch("winner", 32'(due.winner), 32'(res_ch.winner));
        if (res_ch.found !== due.found)
          report_mismatch("found", 32'(due.found), 32'(res_ch.found));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

endmodule
